>>> sv/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, codes and defaults of the port scan source tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

   // table geometry defaults
   localparam int unsigned DefMaxSources     = 256;
   localparam int unsigned DefPortsPerSource = 256;

   // fixed field widths
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned COUNT_W     = 9;
   localparam int unsigned TICK_W      = 16;
   localparam int unsigned PORT_W      = 16;
   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned PROTO_W     = 8;

   // register reset values
   localparam logic [8:0]  RST_SCAN_MIN    = 9'd45;
   localparam logic [15:0] RST_BURST       = 16'd10;
   localparam logic [8:0]  RST_HEAVY       = 9'd250;
   localparam logic [15:0] RST_QUIET_REL   = 16'd30;
   localparam logic [15:0] RST_BLOCKED_REL = 16'd300;

   // command codes
   localparam logic CMD_PACKET = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // tracked protocols
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_SCAN_MIN    = 3'd0,
      CSR_BURST       = 3'd1,
      CSR_HEAVY       = 3'd2,
      CSR_QUIET_REL   = 3'd3,
      CSR_BLOCKED_REL = 3'd4
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PORTS,
      ST_UPDATE,
      ST_INSERT,
      ST_DONE
   } state_type;

   // one result transaction
   typedef struct packed {
      logic         source_blocked;
      logic [8:0]   distinct_ports;
      logic         new_source;
      logic         evicted_oldest;
      logic [8:0]   released_count;
      logic [8:0]   newly_blocked_count;
      logic [8:0]   active_sources;
   } result_type;

   // saturating 16-bit increment
   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

`default_nettype wire

>>> sv/pst_if.sv
// ----------------------------------------------------------------------------
// pst_if
// Request and response channel interfaces of the port scan source tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pst_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [pst_pkg::ADDR_W-1:0]   src_addr;
   logic [pst_pkg::PROTO_W-1:0]  protocol;
   logic [pst_pkg::PORT_W-1:0]   dst_port;

   modport source (output valid, command, src_addr, protocol, dst_port, input ready);
   modport sink   (input valid, command, src_addr, protocol, dst_port, output ready);
endinterface

interface pst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          source_blocked;
   logic [pst_pkg::COUNT_W-1:0]   distinct_ports;
   logic                          new_source;
   logic                          evicted_oldest;
   logic [pst_pkg::COUNT_W-1:0]   released_count;
   logic [pst_pkg::COUNT_W-1:0]   newly_blocked_count;
   logic [pst_pkg::COUNT_W-1:0]   active_sources;

   modport source (output valid, source_blocked, distinct_ports, new_source,
                   evicted_oldest, released_count, newly_blocked_count,
                   active_sources, input ready);
   modport sink   (input valid, source_blocked, distinct_ports, new_source,
                   evicted_oldest, released_count, newly_blocked_count,
                   active_sources, output ready);
endinterface

`default_nettype wire

>>> sv/pst_port_ram.sv
// ----------------------------------------------------------------------------
// pst_port_ram
// Single write, single read port store with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pst_port_ram #(
   parameter int unsigned DEPTH = pst_pkg::DefMaxSources * pst_pkg::DefPortsPerSource,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        we,
   input  wire logic [AW-1:0]               waddr,
   input  wire logic [pst_pkg::PORT_W-1:0]  wdata,
   input  wire logic [AW-1:0]               raddr,
   output logic      [pst_pkg::PORT_W-1:0]  rdata
);

   logic [pst_pkg::PORT_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> sv/port_scan_source_tracker_top.sv
// ----------------------------------------------------------------------------
// port_scan_source_tracker_top
// Tracks TCP/UDP sources and their destination ports in an entry memory and
// a port memory, blocks scanners on a tick and ages out quiet entries.
// ----------------------------------------------------------------------------
//   channel | dir | transaction
//   req     | in  | packet (command 0) or one second tick (command 1)
//   rsp     | out | one result per request
//   csr     | in  | register write, index and data, no read-back
//
// A tick or tracked-protocol packet walks all MAX_SOURCES entries of the
// entry memory, one per cycle; a known source then walks its stored ports
// in the port memory, one per cycle. Untracked protocols skip both walks.
// Reset is synchronous; valid bits clear at once, no clearing pass. One
// request is in flight at a time; a stalled response holds in its register
// and the next request is still taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module port_scan_source_tracker_top #(
   parameter int unsigned MAX_SOURCES      = pst_pkg::DefMaxSources,
   parameter int unsigned PORTS_PER_SOURCE = pst_pkg::DefPortsPerSource
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   pst_req_if.sink                                req,
   pst_rsp_if.source                              rsp,
   input  wire logic                              csr_we,
   input  wire logic [pst_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [pst_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned AW   = $clog2(MAX_SOURCES);
   localparam int unsigned CW   = $clog2(MAX_SOURCES + 1);
   localparam int unsigned FW   = $clog2(PORTS_PER_SOURCE + 1);
   localparam int unsigned PAW  = $clog2(MAX_SOURCES * PORTS_PER_SOURCE);
   localparam int unsigned CMPW = (FW > 9) ? FW : 9;

   typedef struct packed {
      logic [31:0]   addr;
      logic [FW-1:0] fill;
      logic [15:0]   tick_new;
      logic [15:0]   quiet;
      logic          blocked;
      logic [31:0]   stamp;
   } entry_type;

   // state and configuration
   pst_pkg::state_type state_ff, state_in;
   logic [8:0]  smin_ff, smin_in;
   logic [15:0] burst_ff, burst_in;
   logic [8:0]  heavy_ff, heavy_in;
   logic [15:0] qrel_ff, qrel_in;
   logic [15:0] brel_ff, brel_in;

   // captured request
   logic        cmd_ff, cmd_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] port_ff, port_in;

   // entry walk
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rv_ff, rv_in;
   logic [AW-1:0] ridx_ff, ridx_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   entry_type     hit_ent_ff, hit_ent_in;
   logic          free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic          old_any_ff, old_any_in;
   logic [AW-1:0] old_idx_ff, old_idx_in;
   logic [31:0]   old_age_ff, old_age_in;
   logic [8:0]    rel_ff, rel_in;
   logic [8:0]    nb_ff, nb_in;

   // table bookkeeping
   logic [CW-1:0]          total_ff, total_in;
   logic [31:0]            stamp_ff, stamp_in;
   logic [MAX_SOURCES-1:0] valid_ff, valid_in;

   // port walk
   logic [FW-1:0]  pcnt_ff, pcnt_in;
   logic           pv_ff, pv_in;
   logic           seen_ff, seen_in;
   logic [PAW-1:0] base_ff, base_in;
   logic [AW-1:0]  slot_ff, slot_in;
   logic           full_ff, full_in;

   // response
   pst_pkg::result_type res_ff, res_in;
   pst_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // memory controls
   logic          ent_we;
   logic [AW-1:0] ent_waddr;
   entry_type     ent_wdata;
   entry_type     ent_q;
   entry_type     ent_mem [MAX_SOURCES];
   logic           prt_we;
   logic [PAW-1:0] prt_waddr;
   logic [15:0]    prt_wdata;
   logic [PAW-1:0] prt_raddr;
   logic [15:0]    prt_q;

   logic scan_end, ports_end, rsp_free, tracked, full_now;

   assign tracked  = (req.protocol == pst_pkg::PROTO_TCP) ||
                     (req.protocol == pst_pkg::PROTO_UDP);
   assign scan_end  = (cnt_ff == CW'(MAX_SOURCES)) && !rv_ff;
   assign ports_end = (pcnt_ff == hit_ent_ff.fill) && !pv_ff;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign full_now  = (total_ff >= CW'(MAX_SOURCES));

   // entry memory
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_q <= ent_mem[cnt_ff[AW-1:0]];
   end

   pst_port_ram #(
      .DEPTH (MAX_SOURCES * PORTS_PER_SOURCE),
      .AW    (PAW)
   ) u_port_ram (
      .clock (clock),
      .we    (prt_we),
      .waddr (prt_waddr),
      .wdata (prt_wdata),
      .raddr (prt_raddr),
      .rdata (prt_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pst_pkg::ST_IDLE: begin
            if (req.valid) begin
               if (req.command == pst_pkg::CMD_TICK || tracked) begin
                  state_in = pst_pkg::ST_SCAN;
               end else begin
                  state_in = pst_pkg::ST_DONE;
               end
            end
         end
         pst_pkg::ST_SCAN: begin
            if (scan_end) begin
               if (cmd_ff == pst_pkg::CMD_TICK) begin
                  state_in = pst_pkg::ST_DONE;
               end else if (hit_ff) begin
                  state_in = pst_pkg::ST_PORTS;
               end else begin
                  state_in = pst_pkg::ST_INSERT;
               end
            end
         end
         pst_pkg::ST_PORTS: begin
            if (ports_end) begin
               state_in = pst_pkg::ST_UPDATE;
            end
         end
         pst_pkg::ST_UPDATE: state_in = pst_pkg::ST_DONE;
         pst_pkg::ST_INSERT: state_in = pst_pkg::ST_DONE;
         pst_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = pst_pkg::ST_IDLE;
            end
         end
         default: state_in = pst_pkg::ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req.ready = (state_ff == pst_pkg::ST_IDLE);
      rsp.valid = rsp_valid_ff;
      rsp.source_blocked      = rsp_ff.source_blocked;
      rsp.distinct_ports      = rsp_ff.distinct_ports;
      rsp.new_source          = rsp_ff.new_source;
      rsp.evicted_oldest      = rsp_ff.evicted_oldest;
      rsp.released_count      = rsp_ff.released_count;
      rsp.newly_blocked_count = rsp_ff.newly_blocked_count;
      rsp.active_sources      = rsp_ff.active_sources;
   end

   // datapath
   always_comb begin
      logic      v;
      entry_type e;
      entry_type u;
      logic [31:0] age;
      logic [CMPW-1:0] fz;
      logic newb, bl, rel;
      logic [15:0] q1;

      smin_in = smin_ff; burst_in = burst_ff; heavy_in = heavy_ff;
      qrel_in = qrel_ff; brel_in = brel_ff;
      cmd_in = cmd_ff; addr_in = addr_ff; port_in = port_ff;
      cnt_in = cnt_ff; rv_in = 1'b0; ridx_in = ridx_ff;
      hit_in = hit_ff; hit_idx_in = hit_idx_ff; hit_ent_in = hit_ent_ff;
      free_in = free_ff; free_idx_in = free_idx_ff;
      old_any_in = old_any_ff; old_idx_in = old_idx_ff; old_age_in = old_age_ff;
      rel_in = rel_ff; nb_in = nb_ff;
      total_in = total_ff; stamp_in = stamp_ff; valid_in = valid_ff;
      pcnt_in = pcnt_ff; pv_in = 1'b0; seen_in = seen_ff;
      base_in = base_ff; slot_in = slot_ff; full_in = full_ff;
      res_in = res_ff; rsp_in = rsp_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;
      ent_we = 1'b0; ent_waddr = ridx_ff; ent_wdata = ent_q;
      prt_we = 1'b0; prt_waddr = base_ff; prt_wdata = port_ff;
      prt_raddr = base_ff + PAW'(pcnt_ff);
      v = valid_ff[ridx_ff];
      e = ent_q;
      u = hit_ent_ff;
      age = stamp_ff - ent_q.stamp;
      fz = CMPW'(ent_q.fill);
      newb = 1'b0; bl = 1'b0; rel = 1'b0; q1 = '0;

      // configuration writes
      if (csr_we) begin
         case (pst_pkg::csr_index_type'(csr_index))
            pst_pkg::CSR_SCAN_MIN:    smin_in  = csr_wdata[8:0];
            pst_pkg::CSR_BURST:       burst_in = csr_wdata;
            pst_pkg::CSR_HEAVY:       heavy_in = csr_wdata[8:0];
            pst_pkg::CSR_QUIET_REL:   qrel_in  = csr_wdata;
            pst_pkg::CSR_BLOCKED_REL: brel_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         // capture a request transaction
         pst_pkg::ST_IDLE: begin
            if (req.valid) begin
               cmd_in = req.command; addr_in = req.src_addr; port_in = req.dst_port;
               cnt_in = '0; hit_in = 1'b0; free_in = 1'b0; old_any_in = 1'b0;
               rel_in = '0; nb_in = '0;
               res_in = '0;
               res_in.active_sources = 9'(total_ff);
            end
         end
         // walk all entries: lookup for packets, aging for ticks
         pst_pkg::ST_SCAN: begin
            if (cnt_ff != CW'(MAX_SOURCES)) begin
               cnt_in  = cnt_ff + CW'(1);
               rv_in   = 1'b1;
               ridx_in = cnt_ff[AW-1:0];
            end
            if (rv_ff && cmd_ff == pst_pkg::CMD_TICK && v) begin
               newb = !e.blocked && (fz > CMPW'(smin_ff)) &&
                      ((e.tick_new >= burst_ff) || (fz >= CMPW'(heavy_ff)));
               bl = e.blocked || newb;
               q1 = newb ? 16'd0 : e.quiet;
               if (e.tick_new == 16'd0) begin
                  q1  = pst_pkg::sat_inc16(q1);
                  rel = (!bl && q1 >= qrel_ff) || (bl && q1 >= brel_ff);
               end
               if (newb) begin
                  nb_in = nb_ff + 9'd1;
               end
               if (rel) begin
                  valid_in[ridx_ff] = 1'b0;
                  rel_in = rel_ff + 9'd1;
                  total_in = total_ff - CW'(1);
               end else begin
                  ent_we = 1'b1;
                  ent_wdata = e;
                  ent_wdata.blocked = bl;
                  ent_wdata.quiet = q1;
                  ent_wdata.tick_new = '0;
               end
            end
            if (rv_ff && cmd_ff == pst_pkg::CMD_PACKET) begin
               if (v && e.addr == addr_ff && !hit_ff) begin
                  hit_in = 1'b1; hit_idx_in = ridx_ff; hit_ent_in = e;
               end
               if (!v && !free_ff) begin
                  free_in = 1'b1; free_idx_in = ridx_ff;
               end
               if (v && (!old_any_ff || age > old_age_ff)) begin
                  old_any_in = 1'b1; old_idx_in = ridx_ff; old_age_in = age;
               end
            end
            if (scan_end) begin
               if (cmd_ff == pst_pkg::CMD_TICK) begin
                  res_in = '0;
                  res_in.released_count = rel_ff;
                  res_in.newly_blocked_count = nb_ff;
                  res_in.active_sources = 9'(total_ff);
               end else begin
                  full_in = !hit_ff && full_now;
                  slot_in = hit_ff ? hit_idx_ff :
                            (full_now ? old_idx_ff : free_idx_ff);
                  base_in = PAW'(hit_ff ? hit_idx_ff :
                                 (full_now ? old_idx_ff : free_idx_ff)) *
                            PAW'(PORTS_PER_SOURCE);
                  pcnt_in = '0;
                  seen_in = 1'b0;
               end
            end
         end
         // walk the stored ports of a known source
         pst_pkg::ST_PORTS: begin
            if (pcnt_ff != hit_ent_ff.fill) begin
               pcnt_in = pcnt_ff + FW'(1);
               pv_in   = 1'b1;
            end
            if (pv_ff && prt_q == port_ff) begin
               seen_in = 1'b1;
            end
         end
         // record a new port for a known source
         pst_pkg::ST_UPDATE: begin
            if (!seen_ff) begin
               if (hit_ent_ff.fill != FW'(PORTS_PER_SOURCE)) begin
                  prt_we = 1'b1;
                  prt_waddr = base_ff + PAW'(hit_ent_ff.fill);
                  u.fill = hit_ent_ff.fill + FW'(1);
                  u.tick_new = pst_pkg::sat_inc16(hit_ent_ff.tick_new);
               end else if (hit_ent_ff.blocked) begin
                  u.tick_new = pst_pkg::sat_inc16(hit_ent_ff.tick_new);
               end
            end
            ent_we = 1'b1; ent_waddr = slot_ff; ent_wdata = u;
            res_in = '0;
            res_in.source_blocked = u.blocked;
            res_in.distinct_ports = 9'(u.fill);
            res_in.active_sources = 9'(total_ff);
         end
         // new source, replacing the oldest when the table is full
         pst_pkg::ST_INSERT: begin
            ent_we = 1'b1; ent_waddr = slot_ff;
            ent_wdata.addr = addr_ff;
            ent_wdata.fill = FW'(1);
            ent_wdata.tick_new = '0;
            ent_wdata.quiet = '0;
            ent_wdata.blocked = 1'b0;
            ent_wdata.stamp = stamp_ff;
            prt_we = 1'b1; prt_waddr = base_ff;
            valid_in[slot_ff] = 1'b1;
            stamp_in = stamp_ff + 32'd1;
            if (!full_ff) begin
               total_in = total_ff + CW'(1);
            end
            res_in = '0;
            res_in.distinct_ports = 9'd1;
            res_in.new_source = 1'b1;
            res_in.evicted_oldest = full_ff;
            res_in.active_sources = full_ff ? 9'(total_ff) : 9'(total_ff + CW'(1));
         end
         // hand the result to the output register
         pst_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pst_pkg::ST_IDLE;
         smin_ff <= pst_pkg::RST_SCAN_MIN;
         burst_ff <= pst_pkg::RST_BURST;
         heavy_ff <= pst_pkg::RST_HEAVY;
         qrel_ff <= pst_pkg::RST_QUIET_REL;
         brel_ff <= pst_pkg::RST_BLOCKED_REL;
         rv_ff <= 1'b0;
         pv_ff <= 1'b0;
         total_ff <= '0;
         stamp_ff <= '0;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         smin_ff <= smin_in;
         burst_ff <= burst_in;
         heavy_ff <= heavy_in;
         qrel_ff <= qrel_in;
         brel_ff <= brel_in;
         rv_ff <= rv_in;
         pv_ff <= pv_in;
         total_ff <= total_in;
         stamp_ff <= stamp_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; addr_ff <= addr_in; port_ff <= port_in;
      cnt_ff <= cnt_in; ridx_ff <= ridx_in;
      hit_ff <= hit_in; hit_idx_ff <= hit_idx_in; hit_ent_ff <= hit_ent_in;
      free_ff <= free_in; free_idx_ff <= free_idx_in;
      old_any_ff <= old_any_in; old_idx_ff <= old_idx_in; old_age_ff <= old_age_in;
      rel_ff <= rel_in; nb_ff <= nb_in;
      pcnt_ff <= pcnt_in; seen_ff <= seen_in;
      base_ff <= base_in; slot_ff <= slot_in; full_ff <= full_in;
      res_ff <= res_in; rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

>>> sv/pst_checker.sv
// ----------------------------------------------------------------------------
// pst_checker
// Port-level checks of the port scan source tracker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pst_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_source_blocked,
   input wire logic [8:0] rsp_distinct_ports,
   input wire logic       rsp_new_source,
   input wire logic       rsp_evicted_oldest,
   input wire logic [8:0] rsp_released_count,
   input wire logic [8:0] rsp_newly_blocked_count,
   input wire logic [8:0] rsp_active_sources
);

   // an eviction only happens to make room for a new source
   a_evict_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_oldest |-> rsp_new_source)
      else $error("eviction without new source");

   // a fresh entry holds one port and is never blocked
   a_new_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_source |-> rsp_distinct_ports == 9'd1 &&
      !rsp_source_blocked && rsp_active_sources != 9'd0)
      else $error("new source result inconsistent");

   // tick counts and packet fields never share a transaction
   a_tick_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_released_count != 9'd0 || rsp_newly_blocked_count != 9'd0)
      |-> rsp_distinct_ports == 9'd0 && !rsp_new_source && !rsp_source_blocked)
      else $error("tick and packet fields mixed");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distinct_ports) &&
      $stable(rsp_active_sources) && $stable(rsp_released_count))
      else $error("stalled response changed");

endmodule

bind port_scan_source_tracker_top pst_checker u_pst_checker (
   .clock                   (clock),
   .reset                   (reset),
   .rsp_valid               (rsp.valid),
   .rsp_ready               (rsp.ready),
   .rsp_source_blocked      (rsp.source_blocked),
   .rsp_distinct_ports      (rsp.distinct_ports),
   .rsp_new_source          (rsp.new_source),
   .rsp_evicted_oldest      (rsp.evicted_oldest),
   .rsp_released_count      (rsp.released_count),
   .rsp_newly_blocked_count (rsp.newly_blocked_count),
   .rsp_active_sources      (rsp.active_sources)
);

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the port scan source tracker. A local table model
// predicts each response. Directed tests cover field extremes, blocking,
// release, full port lists and eviction. Random traffic then runs under
// several register settings and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int NSRC   = int'(pst_pkg::DefMaxSources);
   localparam int NPORT  = int'(pst_pkg::DefPortsPerSource);
   localparam int WD_MAX = 20000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [pst_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pst_pkg::CSR_DATA_W-1:0]  csr_wdata;

   pst_req_if req();
   pst_rsp_if rsp();

   port_scan_source_tracker_top uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // table model
   bit          tbl_valid   [NSRC];
   bit [31:0]   tbl_addr    [NSRC];
   bit [15:0]   tbl_ports   [NSRC][NPORT];
   int unsigned tbl_fill    [NSRC];
   int unsigned tbl_new     [NSRC];
   int unsigned tbl_quiet   [NSRC];
   bit          tbl_blocked [NSRC];
   bit [31:0]   tbl_stamp   [NSRC];
   bit [31:0]   stamp_next;
   int unsigned table_count;

   // register copies
   int unsigned cfg_scan_min, cfg_burst, cfg_heavy, cfg_quiet_rel, cfg_blocked_rel;

   pst_pkg::result_type expected_results[$];
   int          error_count;
   int          sent_count, got_count, tick_count, evict_count, block_count;
   int          snd_idle_pct, rcv_idle_pct;
   bit          hold_request;
   bit [31:0]   addr_pool[40];

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned sat16(int unsigned v);
      return (v < 16'hFFFF) ? v + 1 : 16'hFFFF;
   endfunction

   function automatic void free_entry(int s);
      tbl_valid[s]   = 1'b0;
      tbl_fill[s]    = 0;
      tbl_new[s]     = 0;
      tbl_quiet[s]   = 0;
      tbl_blocked[s] = 1'b0;
      if (table_count > 0) table_count--;
   endfunction

   // predicted response for one request, updating the table model
   function automatic pst_pkg::result_type track_item(bit cmd, bit [31:0] addr,
                                                      bit [7:0] proto, bit [15:0] port);
      pst_pkg::result_type r;
      int s, i, best, slot;
      bit hit, seen, any;
      bit [31:0] age, best_age;
      r = '0;
      slot = -1;
      if (cmd == pst_pkg::CMD_TICK) begin
         for (s = 0; s < NSRC; s++) begin
            if (!tbl_valid[s]) continue;
            if (!tbl_blocked[s] && tbl_fill[s] > cfg_scan_min &&
                (tbl_new[s] >= cfg_burst || tbl_fill[s] >= cfg_heavy)) begin
               tbl_blocked[s] = 1'b1;
               tbl_quiet[s] = 0;
               r.newly_blocked_count++;
               block_count++;
            end
            if (tbl_new[s] == 0) begin
               tbl_quiet[s] = sat16(tbl_quiet[s]);
               if ((!tbl_blocked[s] && tbl_quiet[s] >= cfg_quiet_rel) ||
                   (tbl_blocked[s] && tbl_quiet[s] >= cfg_blocked_rel)) begin
                  free_entry(s);
                  r.released_count++;
                  continue;
               end
            end
            tbl_new[s] = 0;
         end
      end else if (proto == pst_pkg::PROTO_TCP || proto == pst_pkg::PROTO_UDP) begin
         hit = 1'b0;
         for (s = 0; s < NSRC && !hit; s++)
            if (tbl_valid[s] && tbl_addr[s] == addr) begin
               hit = 1'b1;
               slot = s;
            end
         if (hit) begin
            seen = 1'b0;
            for (i = 0; i < tbl_fill[slot]; i++)
               if (tbl_ports[slot][i] == port) seen = 1'b1;
            if (!seen) begin
               if (tbl_fill[slot] < NPORT) begin
                  tbl_ports[slot][tbl_fill[slot]] = port;
                  tbl_fill[slot]++;
                  tbl_new[slot] = sat16(tbl_new[slot]);
               end else if (tbl_blocked[slot]) begin
                  tbl_new[slot] = sat16(tbl_new[slot]);
               end
            end
         end else begin
            if (table_count >= NSRC) begin
               any = 1'b0;
               best = 0;
               best_age = '0;
               for (s = 0; s < NSRC; s++)
                  if (tbl_valid[s]) begin
                     age = stamp_next - tbl_stamp[s];
                     if (!any || age > best_age) begin
                        best = s;
                        best_age = age;
                        any = 1'b1;
                     end
                  end
               if (any) free_entry(best);
               r.evicted_oldest = 1'b1;
               evict_count++;
            end
            for (s = 0; s < NSRC && slot < 0; s++)
               if (!tbl_valid[s]) slot = s;
            if (slot >= 0) begin
               tbl_valid[slot]    = 1'b1;
               tbl_addr[slot]     = addr;
               tbl_ports[slot][0] = port;
               tbl_fill[slot]     = 1;
               tbl_new[slot]      = 0;
               tbl_quiet[slot]    = 0;
               tbl_blocked[slot]  = 1'b0;
               tbl_stamp[slot]    = stamp_next;
               stamp_next++;
               table_count++;
               r.new_source = 1'b1;
            end
         end
         if (slot >= 0) begin
            r.source_blocked = tbl_blocked[slot];
            r.distinct_ports = 9'(tbl_fill[slot]);
         end
      end
      r.active_sources = 9'(table_count);
      return r;
   endfunction

   // one request transaction; valid stays high for a following request
   task automatic send_item(bit cmd, bit [31:0] addr, bit [7:0] proto, bit [15:0] port);
      if ($urandom_range(99) < snd_idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.command  <= cmd;
      req.src_addr <= addr;
      req.protocol <= proto;
      req.dst_port <= port;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expected_results.push_back(track_item(cmd, addr, proto, port));
      sent_count++;
      if (cmd == pst_pkg::CMD_TICK) tick_count++;
   endtask

   task automatic send_packet(bit [31:0] addr, bit [15:0] port);
      send_item(pst_pkg::CMD_PACKET, addr,
                ($urandom_range(1) ? pst_pkg::PROTO_TCP : pst_pkg::PROTO_UDP), port);
   endtask

   task automatic send_tick();
      send_item(pst_pkg::CMD_TICK, $urandom, 8'($urandom), 16'($urandom));
   endtask

   // sender pauses until every response is back
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(pst_pkg::csr_index_type idx, int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         pst_pkg::CSR_SCAN_MIN:    cfg_scan_min    = value & 9'h1FF;
         pst_pkg::CSR_BURST:       cfg_burst       = value & 16'hFFFF;
         pst_pkg::CSR_HEAVY:       cfg_heavy       = value & 9'h1FF;
         pst_pkg::CSR_QUIET_REL:   cfg_quiet_rel   = value & 16'hFFFF;
         pst_pkg::CSR_BLOCKED_REL: cfg_blocked_rel = value & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic set_regs(int unsigned scan_min, int unsigned burst, int unsigned heavy,
                           int unsigned quiet_rel, int unsigned blocked_rel);
      drain();
      write_reg(pst_pkg::CSR_SCAN_MIN, scan_min);
      write_reg(pst_pkg::CSR_BURST, burst);
      write_reg(pst_pkg::CSR_HEAVY, heavy);
      write_reg(pst_pkg::CSR_QUIET_REL, quiet_rel);
      write_reg(pst_pkg::CSR_BLOCKED_REL, blocked_rel);
   endtask

   // field extremes, untracked protocols, repeated ports, blocking, release
   task automatic test_directed();
      send_tick();
      send_item(pst_pkg::CMD_PACKET, 32'h0, pst_pkg::PROTO_TCP, 16'h0);
      send_item(pst_pkg::CMD_PACKET, 32'hFFFF_FFFF, pst_pkg::PROTO_UDP, 16'hFFFF);
      send_item(pst_pkg::CMD_PACKET, 32'h0, pst_pkg::PROTO_TCP, 16'h0);
      send_item(pst_pkg::CMD_PACKET, 32'h0, pst_pkg::PROTO_UDP, 16'hFFFF);
      send_item(pst_pkg::CMD_PACKET, 32'h1234_5678, 8'd0, 16'h5555);
      send_item(pst_pkg::CMD_PACKET, 32'hFFFF_FFFF, 8'd255, 16'hAAAA);
      send_item(pst_pkg::CMD_PACKET, 32'h0, 8'd7, 16'h1);
      send_tick();
      // low thresholds block on the next tick
      set_regs(0, 1, 0, 1, 1);
      send_packet(32'hA5A5_5A5A, 16'd80);
      send_packet(32'hA5A5_5A5A, 16'd443);
      send_packet(32'hA5A5_5A5A, 16'd80);
      send_tick();
      send_packet(32'hA5A5_5A5A, 16'd22);
      send_tick();
      send_tick();
      send_tick();
      // highest thresholds never block, quiet entries stay
      set_regs(256, 65535, 256, 65535, 65535);
      send_packet(32'h0A00_0001, 16'd1);
      send_packet(32'h0A00_0001, 16'd2);
      send_tick();
      send_tick();
   endtask

   // one source fills its port list, unblocked and then blocked
   task automatic test_full_port_list();
      int i;
      set_regs(256, 65535, 256, 65535, 65535);
      for (i = 0; i < NPORT + 2; i++) send_packet(32'hC0A8_0101, 16'(i * 251));
      send_tick();
      set_regs(45, 10, 250, 30, 300);
      send_tick();
      for (i = 0; i < 3; i++) send_packet(32'hC0A8_0101, 16'(60000 + i));
      send_packet(32'hC0A8_0101, 16'd0);
      send_tick();
   endtask

   // fill the table past its size so the oldest sources are evicted
   task automatic test_eviction();
      int i;
      set_regs(45, 10, 250, 65535, 65535);
      for (i = 0; i < NSRC + 6; i++) send_packet(32'hAC10_0000 + i, 16'(i));
      send_packet(32'hAC10_0100, 16'd7);
      // receiver holds off while requests keep coming
      hold_request = 1'b1;
      for (i = 0; i < 4; i++) send_packet(32'hAC20_0000 + i, 16'd9);
      send_tick();
   endtask

   // random traffic: a small pool of sources with occasional noise
   task automatic test_random(int n_items);
      int i, k;
      bit [31:0] a;
      for (i = 0; i < n_items; i++) begin
         k = $urandom_range(99);
         a = ($urandom_range(9) == 0) ? $urandom : addr_pool[$urandom_range(39)];
         if (k < 12) send_tick();
         else if (k < 20) send_item(pst_pkg::CMD_PACKET, a, 8'($urandom), 16'($urandom));
         else if (k < 30) send_packet(a, 16'($urandom));
         else send_packet(a, 16'($urandom_range(60)));
         if (i == n_items / 2) hold_request = 1'b1;
      end
   endtask

   // response checking
   function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   int hold_cnt;
   always @(posedge clock) begin
      pst_pkg::result_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_cnt  = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got_count++;
            if (expected_results.size() == 0) begin
               $display("%0t unexpected response transaction", $time);
               error_count++;
            end else begin
               e = expected_results.pop_front();
               check_field("source_blocked", e.source_blocked, rsp.source_blocked);
               check_field("distinct_ports", e.distinct_ports, rsp.distinct_ports);
               check_field("new_source", e.new_source, rsp.new_source);
               check_field("evicted_oldest", e.evicted_oldest, rsp.evicted_oldest);
               check_field("released_count", e.released_count, rsp.released_count);
               check_field("newly_blocked_count", e.newly_blocked_count,
                           rsp.newly_blocked_count);
               check_field("active_sources", e.active_sources, rsp.active_sources);
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_cnt = 3000;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transaction
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WD_MAX) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // main sequence
   initial begin
      int i;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.command = 1'b0;
      req.src_addr = '0;
      req.protocol = '0;
      req.dst_port = '0;
      hold_request = 1'b0;
      error_count = 0;
      sent_count = 0;
      got_count = 0;
      tick_count = 0;
      evict_count = 0;
      block_count = 0;
      stamp_next = '0;
      table_count = 0;
      for (i = 0; i < NSRC; i++) free_entry(i);
      table_count = 0;
      cfg_scan_min = pst_pkg::RST_SCAN_MIN;
      cfg_burst = pst_pkg::RST_BURST;
      cfg_heavy = pst_pkg::RST_HEAVY;
      cfg_quiet_rel = pst_pkg::RST_QUIET_REL;
      cfg_blocked_rel = pst_pkg::RST_BLOCKED_REL;
      for (i = 0; i < 40; i++) addr_pool[i] = $urandom;
      snd_idle_pct = 32;
      rcv_idle_pct = 61;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_port_list();
      test_eviction();
      set_regs(4, 3, 20, 3, 6);
      test_random(200);
      snd_idle_pct = 61;
      rcv_idle_pct = 32;
      set_regs(0, 0, 0, 1, 1);
      test_random(100);
      set_regs(10, 65535, 256, 2, 65535);
      test_random(100);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      set_regs(45, 10, 250, 30, 300);
      test_random(200);
      drain();
      repeat (600) @(posedge clock);

      $display("covered %0d requests, %0d ticks, %0d evictions, %0d blockings",
               sent_count, tick_count, evict_count, block_count);
      $display("responses checked: %0d, left over: %0d", got_count,
               expected_results.size());
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/pst_pkg.sv
sv/pst_if.sv
sv/pst_port_ram.sv
sv/port_scan_source_tracker_top.sv
sv/pst_checker.sv
bench/testbench.sv
